FILE: sv/msd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types and constants of the multinomial sum distribution unit.
// ----------------------------------------------------------------------------
package msd_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int MAX_SUM_DEF = 1024;
    localparam int MAX_CAT_DEF = 16;

    // Field widths of the channels
    localparam int OP_W      = 2;
    localparam int VAL_W     = 31;
    localparam int IDX_IN_W  = 11;
    localparam int TOL_W     = 31;
    localparam int TC_W      = 16;
    localparam int KEEP_W    = 32;
    localparam int FRAC_W    = 30;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 32;

    localparam logic [VAL_W-1:0]  ONE_Q30   = 31'h4000_0000;
    localparam logic [VAL_W-1:0]  VAL_MAX   = 31'h7FFF_FFFF;
    localparam logic [KEEP_W-1:0] KEEP_MAX  = 32'hFFFF_FFFF;
    localparam logic [TOL_W-1:0]  TOL_RESET = 31'd1073;

    // Operation codes of an input transaction
    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_CLOSE  = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_ADDR,
        S_RD_DATA,
        S_RD_CALC,
        S_RD_DIV,
        S_RD_OUT,
        S_CL_CHECK,
        S_CL_CLR,
        S_MAC_RD,
        S_MAC_MUL,
        S_MAC_ACC,
        S_CL_TRI,
        S_D_MUL,
        S_D_START,
        S_D_DIV,
        S_CP_RD,
        S_CP_WR,
        S_HS_RD,
        S_HS_CK,
        S_CL_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic rd_addr;
        logic rd_latch;
        logic rd_div_start;
        logic rd_div_take;
        logic rd_raw_take;
        logic publish;
        logic cl_check;
        logic clr_step;
        logic mac_rd;
        logic mac_mul;
        logic mac_acc;
        logic tri_inc;
        logic dmul;
        logic ddiv_start;
        logic ddiv_take;
        logic cp_wr;
        logic hs_rd;
        logic hs_ck;
        logic finish;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_op  in_op;
        logic close_skip;
        logic clr_last;
        logic mac_last_t;
        logic mac_last_j;
        logic first;
        logic norm;
        logic div_done;
        logic cp_last;
        logic hs_stop;
        logic hs_hit;
        logic out_free;
    } t_dp_status;

endpackage

FILE: sv/msd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_if
// Channel interfaces: input transactions, results and tolerance writes.
// ----------------------------------------------------------------------------
interface msd_in_if;
    logic                         valid;
    logic                         ready;
    logic [msd_pkg::OP_W-1:0]     operation;
    logic [msd_pkg::VAL_W-1:0]    probability;
    logic [msd_pkg::IDX_IN_W-1:0] entry_index;

    modport source (output valid, operation, probability, entry_index, input ready);
    modport sink   (input valid, operation, probability, entry_index, output ready);
endinterface

interface msd_out_if;
    logic                      valid;
    logic                      ready;
    logic [msd_pkg::VAL_W-1:0] entry_value;
    logic                      error_flag;

    modport source (output valid, entry_value, error_flag, input ready);
    modport sink   (input valid, entry_value, error_flag, output ready);
endinterface

interface msd_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [msd_pkg::TOL_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: sv/msd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module msd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: sv/msd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msd_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   n_rem_sh;
    logic [DEN_W:0]   n_diff;
    logic             n_ge;

    // Trial subtraction of the shifted remainder
    always_comb begin
        n_rem_sh = {r_rem, r_q[NUM_W-1]};
        n_diff   = n_rem_sh - {1'b0, r_den};
        n_ge     = n_rem_sh >= {1'b0, r_den};
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(NUM_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(NUM_W - 1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Shift quotient bits in, hold the remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            r_q   <= {r_q[NUM_W-2:0], n_ge};
            r_rem <= n_ge ? n_diff[DEN_W-1:0] : n_rem_sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: sv/msd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_datapath
// Distribution store, convolution MAC, tail scans, divider and result slot.
// ----------------------------------------------------------------------------
module msd_datapath #(
    parameter int MAX_SUM        = 1024,
    parameter int MAX_CATEGORIES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  msd_pkg::t_dp_cmd             i_cmd,
    output msd_pkg::t_dp_status          o_status,
    input  logic [msd_pkg::OP_W-1:0]     i_operation,
    input  logic [msd_pkg::VAL_W-1:0]    i_probability,
    input  logic [msd_pkg::IDX_IN_W-1:0] i_entry_index,
    input  logic                         i_cfg_valid,
    input  logic [msd_pkg::TOL_W-1:0]    i_cfg_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [msd_pkg::VAL_W-1:0]    o_entry_value,
    output logic                         o_error_flag
);
    import msd_pkg::*;

    localparam int DEPTH  = MAX_SUM + 1;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CAT_W  = $clog2(MAX_CATEGORIES);
    localparam int LEN_W  = $clog2(MAX_CATEGORIES + 1);
    localparam int SCR_W  = 33 + $clog2(MAX_CATEGORIES);
    localparam int SUM_W  = VAL_W + IDX_W;
    localparam int CMP_W  = (IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W;
    localparam int PROD_W = 2 * VAL_W;
    localparam int DNUM_W = TC_W + TOL_W;

    // Control state (reset)
    logic [TOL_W-1:0]  r_tol;
    logic [LEN_W-1:0]  r_len;
    logic [IDX_W-1:0]  r_lower;
    logic [IDX_W-1:0]  r_upper;
    logic [IDX_W-1:0]  r_total;
    logic [TC_W-1:0]   r_tc;
    logic [KEEP_W-1:0] r_kept;
    logic              r_err;
    logic              r_fresh;
    logic              r_out_valid;

    // Working registers
    logic [CMP_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_top;
    logic [IDX_W-1:0]  r_t;
    logic [IDX_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_newlow;
    logic [CAT_W-1:0]  r_j;
    logic [CAT_W-1:0]  r_cats;
    logic [SCR_W-1:0]  r_sacc;
    logic [PROD_W-1:0] r_prod;
    logic [VAL_W-1:0]  r_val;
    logic [VAL_W-1:0]  r_res;
    logic [DNUM_W-1:0] r_dnum;
    logic [VAL_W-1:0]  r_d;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_lacc;
    logic [SUM_W-1:0]  r_lsum;
    logic [SUM_W-1:0]  r_hacc;
    logic [SUM_W-1:0]  r_hsum;
    logic              r_lfound;
    logic              r_cut;
    logic [VAL_W-1:0]  r_out_val;
    logic              r_out_err;

    // Combinational values
    t_op               n_op;
    logic              n_len_full;
    logic [CAT_W-1:0]  n_cats;
    logic              n_ovf;
    logic [IDX_W-1:0]  n_mac_addr;
    logic [VAL_W-1:0]  n_sat;
    logic [SUM_W-1:0]  n_lacc;
    logic [SUM_W-1:0]  n_hacc;
    logic [SUM_W-1:0]  n_kept_full;
    logic [TC_W-1:0]   n_x;
    logic              n_in_range;
    logic              n_first;
    logic              n_cp_last;

    // Memory ports
    logic [IDX_W-1:0]  dist_raddr;
    logic [VAL_W-1:0]  dist_rdata;
    logic [IDX_W-1:0]  scr_raddr;
    logic [IDX_W-1:0]  scr_waddr;
    logic [SCR_W-1:0]  scr_wdata;
    logic              scr_we;
    logic [SCR_W-1:0]  scr_rdata;
    logic              prob_we;
    logic [VAL_W-1:0]  prob_rdata;

    // Divider ports
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;

    // Decode, bounds and running sums
    always_comb begin
        n_op        = t_op'(i_operation);
        n_len_full  = r_len == LEN_W'(MAX_CATEGORIES);
        n_cats      = r_len[CAT_W-1:0] - CAT_W'(1);
        n_ovf       = ((IDX_W+1)'(r_total) + (IDX_W+1)'(n_cats)) > (IDX_W+1)'(MAX_SUM);
        n_mac_addr  = r_t + IDX_W'(r_j);
        n_sat       = (scr_rdata > SCR_W'(VAL_MAX)) ? VAL_MAX : scr_rdata[VAL_W-1:0];
        n_lacc      = r_lacc + SUM_W'(n_sat);
        n_hacc      = r_hacc + SUM_W'(dist_rdata);
        n_kept_full = r_sum - r_lsum - r_hsum;
        n_x         = r_tc - TC_W'(1);
        n_in_range  = (r_idx >= CMP_W'(r_lower)) && (r_idx <= CMP_W'(r_upper));
        n_first     = r_tc < TC_W'(2);
        n_cp_last   = r_t == r_top;
    end

    // Memory address and data selection
    always_comb begin
        if (i_cmd.rd_addr) begin
            dist_raddr = r_idx[IDX_W-1:0];
        end else if (i_cmd.hs_rd) begin
            dist_raddr = r_i;
        end else begin
            dist_raddr = r_t;
        end
        scr_raddr = i_cmd.mac_rd ? n_mac_addr : r_t;
        scr_we    = i_cmd.clr_step || i_cmd.mac_acc;
        scr_waddr = i_cmd.mac_acc ? n_mac_addr : r_t;
        scr_wdata = i_cmd.mac_acc
                  ? r_sacc + SCR_W'(r_prod[PROD_W-1:FRAC_W]) + SCR_W'(r_prod[FRAC_W-1])
                  : '0;
        prob_we   = i_cmd.accept && (n_op == OP_APPEND) && !n_len_full;
    end

    // Divider operand selection: read normalisation or tail threshold
    always_comb begin
        div_start = i_cmd.rd_div_start || i_cmd.ddiv_start;
        if (i_cmd.rd_div_start) begin
            div_num = (DIV_NUM_W'(r_val) << FRAC_W) + DIV_NUM_W'(r_kept >> 1);
            div_den = DIV_DEN_W'(r_kept);
        end else begin
            div_num = DIV_NUM_W'(r_dnum);
            div_den = DIV_DEN_W'({n_x, 1'b1});
        end
    end

    msd_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_dist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cp_wr),
        .i_waddr (r_t),
        .i_wdata (n_sat),
        .i_raddr (dist_raddr),
        .o_rdata (dist_rdata)
    );

    msd_ram #(.WIDTH(SCR_W), .DEPTH(DEPTH)) u_scratch (
        .i_clk   (i_clk),
        .i_we    (scr_we),
        .i_waddr (scr_waddr),
        .i_wdata (scr_wdata),
        .i_raddr (scr_raddr),
        .o_rdata (scr_rdata)
    );

    msd_ram #(.WIDTH(VAL_W), .DEPTH(MAX_CATEGORIES)) u_probs (
        .i_clk   (i_clk),
        .i_we    (prob_we),
        .i_waddr (r_len[CAT_W-1:0]),
        .i_wdata (i_probability),
        .i_raddr (r_j),
        .o_rdata (prob_rdata)
    );

    msd_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Control state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol       <= TOL_RESET;
            r_len       <= '0;
            r_lower     <= '0;
            r_upper     <= '0;
            r_total     <= '0;
            r_tc        <= '0;
            r_kept      <= KEEP_W'(ONE_Q30);
            r_err       <= 1'b0;
            r_fresh     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tol <= i_cfg_data;
            end
            // Append a category or flag the overflow
            if (i_cmd.accept && (n_op == OP_APPEND)) begin
                if (n_len_full) begin
                    r_err <= 1'b1;
                end else begin
                    r_len <= r_len + LEN_W'(1);
                end
            end
            // Open a close: discard the trial on range overflow
            if (i_cmd.cl_check) begin
                r_len <= '0;
                if (r_len != '0) begin
                    if (n_ovf) begin
                        r_err <= 1'b1;
                    end else begin
                        r_total <= r_total + IDX_W'(n_cats);
                    end
                end
            end
            if (i_cmd.tri_inc) begin
                r_fresh <= 1'b0;
                if (r_tc != '1) begin
                    r_tc <= r_tc + TC_W'(1);
                end
            end
            // End of write-back: place new bounds
            if (i_cmd.cp_wr && n_cp_last) begin
                if (n_first) begin
                    r_upper <= r_top;
                end else if (r_lfound) begin
                    r_lower <= r_newlow;
                end
            end
            if (i_cmd.finish) begin
                r_upper <= r_cut ? r_i : r_top;
                r_kept  <= (n_kept_full > SUM_W'(KEEP_MAX)) ? KEEP_MAX
                                                            : n_kept_full[KEEP_W-1:0];
            end
            // Result slot
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working register updates
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= CMP_W'(i_entry_index);
        end
        if (i_cmd.rd_latch) begin
            r_val <= n_in_range ? (r_fresh ? ONE_Q30 : dist_rdata) : '0;
        end
        if (i_cmd.rd_raw_take) begin
            r_res <= r_val;
        end
        if (i_cmd.rd_div_take) begin
            r_res <= (div_quot > DIV_NUM_W'(VAL_MAX)) ? VAL_MAX : div_quot[VAL_W-1:0];
        end
        if (i_cmd.publish) begin
            r_out_val <= r_res;
            r_out_err <= r_err;
        end
        // Set up the convolution walk
        if (i_cmd.cl_check) begin
            r_top    <= r_upper + IDX_W'(n_cats);
            r_cats   <= n_cats;
            r_t      <= r_lower;
            r_j      <= '0;
            r_sum    <= '0;
            r_lacc   <= '0;
            r_lsum   <= '0;
            r_hacc   <= '0;
            r_hsum   <= '0;
            r_lfound <= 1'b0;
            r_cut    <= 1'b0;
        end
        if (i_cmd.clr_step) begin
            r_t <= n_cp_last ? r_lower : r_t + IDX_W'(1);
        end
        // Multiply one stored entry by one category probability
        if (i_cmd.mac_mul) begin
            r_prod <= PROD_W'(r_fresh ? ONE_Q30 : dist_rdata) * PROD_W'(prob_rdata);
            r_sacc <= scr_rdata;
        end
        if (i_cmd.mac_acc) begin
            if (r_t == r_upper) begin
                r_t <= r_lower;
                r_j <= r_j + CAT_W'(1);
            end else begin
                r_t <= r_t + IDX_W'(1);
            end
        end
        if (i_cmd.dmul) begin
            r_dnum <= n_x * r_tol;
        end
        if (i_cmd.ddiv_take) begin
            r_d <= div_quot[VAL_W-1:0];
        end
        // Write back, total the mass and look for the low cut
        if (i_cmd.cp_wr) begin
            r_sum <= r_sum + SUM_W'(n_sat);
            r_t   <= r_t + IDX_W'(1);
            if (!n_first && !r_lfound && !n_cp_last) begin
                if (n_lacc > SUM_W'(r_d)) begin
                    r_lfound <= 1'b1;
                    r_newlow <= r_t;
                    r_lsum   <= r_lacc;
                end else begin
                    r_lacc <= n_lacc;
                end
            end
            if (n_cp_last) begin
                r_i <= r_top;
            end
        end
        // Walk down from the top for the high cut
        if (i_cmd.hs_ck) begin
            if (n_hacc > SUM_W'(r_d)) begin
                r_cut  <= 1'b1;
                r_hsum <= r_hacc;
            end else begin
                r_hacc <= n_hacc;
                r_i    <= r_i - IDX_W'(1);
            end
        end
    end

    // Status towards the controller
    always_comb begin
        o_status.in_op      = n_op;
        o_status.close_skip = (r_len == '0) || n_ovf;
        o_status.clr_last   = n_cp_last;
        o_status.mac_last_t = r_t == r_upper;
        o_status.mac_last_j = r_j == r_cats;
        o_status.first      = n_first;
        o_status.norm       = ((r_lower != '0) || (r_upper < r_total)) && (r_kept != '0);
        o_status.div_done   = div_done;
        o_status.cp_last    = n_cp_last;
        o_status.hs_stop    = r_i == r_lower;
        o_status.hs_hit     = n_hacc > SUM_W'(r_d);
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_value = r_out_val;
    assign o_error_flag  = r_out_err;
endmodule

FILE: sv/msd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_ctrl
// Sequencer for append, close and read transactions.
// ----------------------------------------------------------------------------
module msd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  msd_pkg::t_dp_status i_status,
    output msd_pkg::t_dp_cmd    o_cmd
);
    import msd_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_status.in_op)
                        OP_CLOSE: n_state = S_CL_CHECK;
                        OP_READ:  n_state = S_RD_ADDR;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_RD_ADDR: begin
                o_cmd.rd_addr = 1'b1;
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                o_cmd.rd_latch = 1'b1;
                n_state = S_RD_CALC;
            end
            S_RD_CALC: begin
                if (i_status.norm) begin
                    o_cmd.rd_div_start = 1'b1;
                    n_state = S_RD_DIV;
                end else begin
                    o_cmd.rd_raw_take = 1'b1;
                    n_state = S_RD_OUT;
                end
            end
            S_RD_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.rd_div_take = 1'b1;
                    n_state = S_RD_OUT;
                end
            end
            S_RD_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CL_CHECK: begin
                o_cmd.cl_check = 1'b1;
                n_state = i_status.close_skip ? S_IDLE : S_CL_CLR;
            end
            S_CL_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_MAC_RD;
                end
            end
            S_MAC_RD: begin
                o_cmd.mac_rd = 1'b1;
                n_state = S_MAC_MUL;
            end
            S_MAC_MUL: begin
                o_cmd.mac_mul = 1'b1;
                n_state = S_MAC_ACC;
            end
            S_MAC_ACC: begin
                o_cmd.mac_acc = 1'b1;
                if (i_status.mac_last_t && i_status.mac_last_j) begin
                    n_state = S_CL_TRI;
                end else begin
                    n_state = S_MAC_RD;
                end
            end
            S_CL_TRI: begin
                o_cmd.tri_inc = 1'b1;
                n_state = S_D_MUL;
            end
            S_D_MUL: begin
                if (i_status.first) begin
                    n_state = S_CP_RD;
                end else begin
                    o_cmd.dmul = 1'b1;
                    n_state = S_D_START;
                end
            end
            S_D_START: begin
                o_cmd.ddiv_start = 1'b1;
                n_state = S_D_DIV;
            end
            S_D_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.ddiv_take = 1'b1;
                    n_state = S_CP_RD;
                end
            end
            S_CP_RD: begin
                n_state = S_CP_WR;
            end
            S_CP_WR: begin
                o_cmd.cp_wr = 1'b1;
                if (!i_status.cp_last) begin
                    n_state = S_CP_RD;
                end else if (i_status.first) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_HS_RD;
                end
            end
            S_HS_RD: begin
                if (i_status.hs_stop) begin
                    n_state = S_CL_DONE;
                end else begin
                    o_cmd.hs_rd = 1'b1;
                    n_state = S_HS_CK;
                end
            end
            S_HS_CK: begin
                o_cmd.hs_ck = 1'b1;
                n_state = i_status.hs_hit ? S_CL_DONE : S_HS_RD;
            end
            S_CL_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

FILE: sv/multinomial_sum_distribution_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multinomial_sum_distribution_unit
// Distribution of a sum of multinomial trials in unsigned Q1.30, with tail trimming.
//
// Channel   Dir  Payload                                  Transaction
// i_in      in   operation, probability, entry_index      append/close/read
// o_out     out  entry_value, error_flag                  one per read
// i_cfg     in   data (tolerance)                         always ready
//
// An append is absorbed in the idle state. A read divides by the kept mass
// (one-bit-per-cycle divider) when the range has been trimmed. A close clears
// the scratch, walks the categories and copies back; after the first close it
// also divides out the tail threshold and seeks the low and high cuts. The
// read-modify-write multiply-accumulate walk over scratch memory dominates.
// Reset is synchronous; no memory clearing pass follows it.
// A finished result waits in the output register; a new transaction is taken
// while it waits, and the next read holds until the slot is free.
// ----------------------------------------------------------------------------
module multinomial_sum_distribution_unit #(
    parameter int MAX_SUM        = msd_pkg::MAX_SUM_DEF,
    parameter int MAX_CATEGORIES = msd_pkg::MAX_CAT_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    msd_in_if.sink   i_in,
    msd_out_if.source o_out,
    msd_cfg_if.sink  i_cfg
);
    import msd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign i_cfg.ready = 1'b1;

    msd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    msd_datapath #(
        .MAX_SUM        (MAX_SUM),
        .MAX_CATEGORIES (MAX_CATEGORIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_operation   (i_in.operation),
        .i_probability (i_in.probability),
        .i_entry_index (i_in.entry_index),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_entry_value (o_out.entry_value),
        .o_error_flag  (o_out.error_flag)
    );
endmodule
